FILE: rtl/ldpg_pkg.sv
// Shared types, constants and polynomial tables of the low-discrepancy point generator.
package ldpg_pkg;

  localparam int DIM_W       = 5;
  localparam int SKIP_W      = 31;
  localparam int COORD_W     = 31;
  localparam int SEQ_W       = 32;
  localparam int PROD_W      = 40;
  localparam int DEG_W       = 6;
  localparam int STEP_W      = 6;
  localparam int J_W         = 5;
  localparam int U_W         = 3;
  localparam int POLY_W      = 8;
  localparam int EXTRA_TERMS = 5;
  localparam int NUM_POLYS   = 20;

  typedef logic [POLY_W-1:0] poly_t;
  typedef logic [U_W-1:0]    pdeg_t;

  // irreducible GF(2) polynomials, bit k is the coefficient of x^k
  localparam poly_t IRR_POLY [NUM_POLYS] = '{
    8'd2,  8'd3,  8'd7,  8'd11, 8'd13, 8'd19, 8'd25, 8'd31, 8'd37, 8'd41,
    8'd47, 8'd55, 8'd59, 8'd61, 8'd67, 8'd73, 8'd87, 8'd91, 8'd97, 8'd103
  };

  // degree of each polynomial above
  localparam pdeg_t IRR_DEG [NUM_POLYS] = '{
    3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
  };

  typedef enum logic [3:0] {
    DP_NOP,
    DP_START_NEXT,
    DP_START_INIT,
    DP_EMIT,
    DP_DIM_START,
    DP_MUL,
    DP_REC,
    DP_COL,
    DP_WRITE
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [DIM_W-1:0]   dim;
    logic [J_W-1:0]     j;
    logic [STEP_W-1:0]  step;
    logic [U_W-1:0]     u;
    logic               rd_en;
    logic [DIM_W-1:0]   rd_dim;
  } dp_cmd_t;

  typedef struct packed {
    logic               out_free;
    logic               dims_ok;
    logic [DIM_W-1:0]   active_dims;
    logic [DEG_W-1:0]   deg;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NX_PRIME,
    ST_NX_RUN,
    ST_BD_START,
    ST_BD_MUL,
    ST_BD_REC,
    ST_BD_COL,
    ST_BD_WR
  } ctrl_state_t;

endpackage

FILE: rtl/low_discrepancy_point_generator_unit.sv
// Top level of the base-2 Niederreiter low-discrepancy point generator.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  kind, skip
//  out      output     out_valid/out_stall coordinate, dim_index, last, exhausted
//  cfg      input      cfg_valid/cfg_ready cfg_data (dimensions)
//
// Next item: the accepting step, one direction table read, then one coordinate per cycle
// while the output is not stalled.
// Init item: the accepting step, then per dimension a start step, B blocks of the
// product/recurrence unit, FRACTION_BITS column fills in all and FRACTION_BITS table writes;
// a block of product degree m runs FRACTION_BITS + EXTRA_TERMS + 1 - m recurrence steps.
// Reset is synchronous; the direction table is undefined until the first init.
// out_stall holds the output register; a new item is taken while a result waits.
module low_discrepancy_point_generator_unit #(
  parameter int FRACTION_BITS = 31,
  parameter int MAX_DIMS      = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [ldpg_pkg::SKIP_W-1:0]       skip,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ldpg_pkg::COORD_W-1:0]      coordinate,
  output logic [ldpg_pkg::DIM_W-1:0]        dim_index,
  output logic                              last,
  output logic                              exhausted,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ldpg_pkg::DIM_W-1:0]        cfg_data
);
  import ldpg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are taken at any time
  assign cfg_ready = 1'b1;

  ldpg_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ldpg_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .skip       (skip),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coordinate (coordinate),
    .dim_index  (dim_index),
    .last       (last),
    .exhausted  (exhausted)
  );

endmodule

FILE: rtl/ldpg_datapath.sv
// Datapath: direction table memory, build scratch, current point, sequence index, output register.
module ldpg_datapath #(
  parameter int FRACTION_BITS = 31,
  parameter int MAX_DIMS      = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ldpg_pkg::dp_cmd_t                 cmd,
  output ldpg_pkg::dp_status_t              status,
  input  logic [ldpg_pkg::SKIP_W-1:0]       skip,
  input  logic                              cfg_valid,
  input  logic [ldpg_pkg::DIM_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ldpg_pkg::COORD_W-1:0]      coordinate,
  output logic [ldpg_pkg::DIM_W-1:0]        dim_index,
  output logic                              last,
  output logic                              exhausted
);
  import ldpg_pkg::*;

  localparam int DEPTH    = MAX_DIMS * FRACTION_BITS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int ROW_W    = $clog2(FRACTION_BITS);
  localparam int RB_W     = FRACTION_BITS + EXTRA_TERMS + 1;
  localparam int RB_IDX_W = $clog2(RB_W);
  localparam int DIX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // storage
  logic [FRACTION_BITS-1:0] mem [DEPTH];
  logic [FRACTION_BITS-1:0] rdata;
  logic [FRACTION_BITS-1:0] mat [FRACTION_BITS];
  logic [FRACTION_BITS-1:0] cp  [MAX_DIMS];
  logic [FRACTION_BITS-1:0] acc;
  logic [FRACTION_BITS-1:0] gray;
  logic [SEQ_W-1:0]         seq;
  logic [DEG_W-1:0]         col;
  logic                     ex;
  logic [PROD_W-1:0]        product;
  logic [DEG_W-1:0]         deg;
  logic [RB_W-1:0]          rb;
  logic [DIM_W-1:0]         dims;
  logic [DIM_W-1:0]         active;

  // combinational helpers
  logic [SEQ_W-1:0]         seq_t;
  logic [DEG_W-1:0]         col_now;
  logic                     ex_now;
  poly_t                    poly;
  pdeg_t                    pdeg;
  logic [DEG_W-1:0]         m_new;
  logic [PROD_W-1:0]        ones;
  logic [PROD_W-1:0]        prod_mul;
  logic [RB_W-1:0]          rb_init;
  logic [PROD_W-1:0]        low;
  logic                     rec_bit;
  logic [RB_IDX_W-1:0]      rec_pos;
  logic [RB_W-1:0]          rb_sh;
  logic [ROW_W-1:0]         col_pos;
  logic [ROW_W-1:0]         row;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DEG_W-1:0]         col_eff;
  logic [FRACTION_BITS-1:0] acc_next;
  logic [DIX_W-1:0]         dix;

  // trailing ones of the sequence index select the column
  always_comb begin
    seq_t   = seq & ~(seq + 1'b1);
    col_now = '0;
    for (int k = 0; k < SEQ_W; k++) begin
      if (seq_t[k]) col_now = DEG_W'(k + 1);
    end
    ex_now = (col_now >= DEG_W'(FRACTION_BITS));
  end

  // polynomial product and recurrence step
  always_comb begin
    poly     = IRR_POLY[cmd.dim];
    pdeg     = IRR_DEG[cmd.dim];
    m_new    = deg + DEG_W'(pdeg);
    ones     = '1;
    prod_mul = '0;
    for (int k = 0; k < POLY_W; k++) begin
      if (poly[k]) prod_mul = prod_mul ^ (product << k);
    end
    rb_init  = RB_W'(~(ones << m_new) & (ones << deg));
    low      = ~(ones << deg) & product;
    rec_bit  = ^((PROD_W'(rb) >> cmd.step) & low);
    rec_pos  = RB_IDX_W'(cmd.step + deg);
  end

  // column fill, table write and read addressing
  always_comb begin
    rb_sh    = rb >> cmd.u;
    col_pos  = ROW_W'(FRACTION_BITS - 1) - cmd.j[ROW_W-1:0];
    row      = cmd.step[ROW_W-1:0];
    dix      = cmd.dim[DIX_W-1:0];
    wr_addr  = ADDR_W'(int'(cmd.dim) * FRACTION_BITS + int'(row));
    col_eff  = ex ? '0 : col;
    rd_addr  = ADDR_W'(int'(cmd.rd_dim) * FRACTION_BITS + int'(col_eff));
    acc_next = acc ^ (gray[row] ? mat[row] : '0);
  end

  // direction table memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.op == DP_WRITE) mem[wr_addr] <= mat[row];
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  // build scratch and transaction payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_START_NEXT: begin
        col <= col_now;
        ex  <= ex_now;
      end
      DP_START_INIT: begin
        gray <= FRACTION_BITS'(skip ^ (skip >> 1));
      end
      DP_DIM_START: begin
        product <= PROD_W'(1);
        deg     <= '0;
        acc     <= '0;
      end
      DP_MUL: begin
        product <= prod_mul;
        deg     <= m_new;
        rb      <= rb_init;
      end
      DP_REC: begin
        rb[rec_pos] <= rec_bit;
      end
      DP_COL: begin
        for (int r = 0; r < FRACTION_BITS; r++) begin
          mat[r][col_pos] <= rb_sh[r];
        end
      end
      DP_WRITE: begin
        acc <= acc_next;
      end
      default: ;
    endcase
    if (cmd.op == DP_EMIT) begin
      coordinate <= COORD_W'(cp[dix]);
      dim_index  <= cmd.dim;
      last       <= (cmd.dim == active - 1'b1);
      exhausted  <= ex;
    end
  end

  // control state: point, index, counts, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIMS; i++) cp[i] <= '0;
      seq       <= '0;
      dims      <= DIM_W'(1);
      active    <= DIM_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) dims <= cfg_data;
      unique case (cmd.op)
        DP_START_NEXT: begin
          if (!ex_now) seq <= seq + 1'b1;
        end
        DP_START_INIT: begin
          active <= dims;
          seq    <= SEQ_W'(skip);
        end
        DP_EMIT: begin
          if (!ex) cp[dix] <= cp[dix] ^ rdata;
        end
        DP_WRITE: begin
          if (row == ROW_W'(FRACTION_BITS - 1)) cp[dix] <= acc_next;
        end
        default: ;
      endcase
      if (cmd.op == DP_EMIT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign status.out_free    = !out_valid || !out_stall;
  assign status.dims_ok     = (dims != '0) && (dims <= DIM_W'(MAX_DIMS));
  assign status.active_dims = active;
  assign status.deg         = deg;

`ifndef SYNTH
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_EMIT |=> out_valid)
    else $error("emitted coordinate not presented");
  a_exhausted_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_START_NEXT && ex_now) |=> seq == $past(seq))
    else $error("sequence index advanced when exhausted");
  a_active_range: assert property (@(posedge clk) disable iff (rst)
    active != '0 && active <= DIM_W'(MAX_DIMS))
    else $error("active dimension count out of range");
`endif

endmodule

FILE: rtl/ldpg_ctrl.sv
// Controller: sequences next-point emission and direction table build.
module ldpg_ctrl #(
  parameter int FRACTION_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   kind,
  input  ldpg_pkg::dp_status_t   status,
  output logic                   in_stall,
  output ldpg_pkg::dp_cmd_t      cmd
);
  import ldpg_pkg::*;

  localparam int RB_W = FRACTION_BITS + EXTRA_TERMS + 1;

  ctrl_state_t        state, state_next;
  logic [DIM_W-1:0]   dim, dim_next;
  logic [J_W-1:0]     j, j_next;
  logic [U_W-1:0]     u, u_next;
  logic [STEP_W-1:0]  step, step_next;

  logic               last_dim;
  logic [U_W-1:0]     u_inc;
  logic [U_W-1:0]     u_wrap;
  logic               rec_last;

  always_comb begin
    last_dim = (dim == status.active_dims - 1'b1);
    u_inc    = u + 1'b1;
    u_wrap   = (u_inc >= IRR_DEG[dim]) ? '0 : u_inc;
    rec_last = (step == STEP_W'(RB_W - 1) - status.deg);
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dim   <= '0;
      j     <= '0;
      u     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      dim   <= dim_next;
      j     <= j_next;
      u     <= u_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    dim_next   = dim;
    j_next     = j;
    u_next     = u;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          dim_next = '0;
          if (kind) state_next = ST_NX_PRIME;
          else if (status.dims_ok) state_next = ST_BD_START;
        end
      end
      ST_NX_PRIME: state_next = ST_NX_RUN;
      ST_NX_RUN: begin
        if (status.out_free) begin
          if (last_dim) state_next = ST_IDLE;
          else dim_next = dim + 1'b1;
        end
      end
      ST_BD_START: begin
        j_next     = '0;
        u_next     = '0;
        state_next = ST_BD_MUL;
      end
      ST_BD_MUL: begin
        step_next  = '0;
        state_next = ST_BD_REC;
      end
      ST_BD_REC: begin
        if (rec_last) state_next = ST_BD_COL;
        else step_next = step + 1'b1;
      end
      ST_BD_COL: begin
        if (j == J_W'(FRACTION_BITS - 1)) begin
          step_next  = '0;
          state_next = ST_BD_WR;
        end else begin
          j_next = j + 1'b1;
          u_next = u_wrap;
          if (u_wrap == '0) state_next = ST_BD_MUL;
        end
      end
      ST_BD_WR: begin
        if (step == STEP_W'(FRACTION_BITS - 1)) begin
          if (last_dim) state_next = ST_IDLE;
          else begin
            dim_next   = dim + 1'b1;
            state_next = ST_BD_START;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_stall   = (state != ST_IDLE);
    cmd.op     = DP_NOP;
    cmd.dim    = dim;
    cmd.j      = j;
    cmd.step   = step;
    cmd.u      = u;
    cmd.rd_en  = 1'b0;
    cmd.rd_dim = dim;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind) cmd.op = DP_START_NEXT;
          else if (status.dims_ok) cmd.op = DP_START_INIT;
        end
      end
      ST_NX_PRIME: cmd.rd_en = 1'b1;
      ST_NX_RUN: begin
        if (status.out_free) begin
          cmd.op = DP_EMIT;
          if (!last_dim) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_dim = dim + 1'b1;
          end
        end
      end
      ST_BD_START: cmd.op = DP_DIM_START;
      ST_BD_MUL:   cmd.op = DP_MUL;
      ST_BD_REC:   cmd.op = DP_REC;
      ST_BD_COL:   cmd.op = DP_COL;
      ST_BD_WR:    cmd.op = DP_WRITE;
      default:     cmd.op = DP_NOP;
    endcase
  end

`ifndef SYNTH
  a_dim_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NX_RUN || state == ST_BD_WR) |-> dim < status.active_dims)
    else $error("dimension counter beyond active count");
  a_u_below_degree: assert property (@(posedge clk) disable iff (rst)
    state == ST_BD_COL |-> u < IRR_DEG[dim])
    else $error("block offset not below polynomial degree");
  a_rec_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_BD_REC |-> step <= STEP_W'(RB_W - 1) - status.deg)
    else $error("recurrence step past end");
`endif

endmodule
